// ===== sv/quaternion_vector_rotate_core_defines.svh =====
// Assertion macros for the rotation core top level.
`ifndef QUATERNION_VECTOR_ROTATE_CORE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_CORE_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define QVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check, also active during reset.
`define QVR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/qvr_pkg.sv =====
// Shared types and constants of the quaternion vector rotation core.
package qvr_pkg;

  localparam int DIV_BITS = 25;

  localparam logic [DIV_BITS-1:0] Q_POS_LIM = 25'h07FFFFF;
  localparam logic [DIV_BITS-1:0] Q_NEG_LIM = 25'h0800000;
  localparam logic [23:0]         SAT_POS   = 24'h7FFFFF;
  localparam logic [23:0]         SAT_NEG   = 24'h800000;

  typedef struct packed {
    logic signed [23:0] quat_w;
    logic signed [23:0] quat_x;
    logic signed [23:0] quat_y;
    logic signed [23:0] quat_z;
    logic signed [23:0] vec_x;
    logic signed [23:0] vec_y;
    logic signed [23:0] vec_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [23:0] rot_x;
    logic signed [23:0] rot_y;
    logic signed [23:0] rot_z;
  } out_beat_t;

  typedef struct packed {
    logic signed [49:0] a;
    logic signed [49:0] d2;
    logic signed [49:0] cx;
    logic signed [49:0] cy;
    logic signed [49:0] cz;
    logic        [48:0] den;
    logic               zero;
    in_beat_t           beat;
  } terms_t;

  typedef struct packed {
    logic        [48:0] den;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] vz;
    logic               zero;
  } carry_t;

  typedef struct packed {
    logic [2:0][77:0] m;
    logic [2:0]       neg;
    carry_t           c;
  } div_in_t;

endpackage

// ===== sv/qvr_terms.sv =====
// Quaternion and vector products, then norm, scalar, dot and cross terms.
module qvr_terms import qvr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     in_v,
  input  in_beat_t in_d,
  output logic     term_v,
  output terms_t   term_d
);

  typedef struct packed {
    logic signed [47:0] ww, xx, yy, zz;
    logic signed [47:0] xvx, yvy, zvz;
    logic signed [47:0] yvz, zvy, zvx, xvz, xvy, yvx;
  } prod_t;

  function automatic logic signed [49:0] ext(input logic signed [47:0] p);
    return {{2{p[47]}}, p};
  endfunction

  logic signed [23:0] w, x, y, z, vx, vy, vz;
  prod_t    prod_nxt, prod_r;
  in_beat_t beat_r;
  logic     v1_r;
  terms_t   term_nxt, term_r;
  logic     term_v_r;
  logic signed [49:0] den_s, dot_s;

  assign w  = in_d.quat_w;
  assign x  = in_d.quat_x;
  assign y  = in_d.quat_y;
  assign z  = in_d.quat_z;
  assign vx = in_d.vec_x;
  assign vy = in_d.vec_y;
  assign vz = in_d.vec_z;

  always_comb begin
    prod_nxt.ww  = w * w;
    prod_nxt.xx  = x * x;
    prod_nxt.yy  = y * y;
    prod_nxt.zz  = z * z;
    prod_nxt.xvx = x * vx;
    prod_nxt.yvy = y * vy;
    prod_nxt.zvz = z * vz;
    prod_nxt.yvz = y * vz;
    prod_nxt.zvy = z * vy;
    prod_nxt.zvx = z * vx;
    prod_nxt.xvz = x * vz;
    prod_nxt.xvy = x * vy;
    prod_nxt.yvx = y * vx;
  end

  always_comb begin
    den_s = ext(prod_r.ww) + ext(prod_r.xx) + ext(prod_r.yy) + ext(prod_r.zz);
    dot_s = ext(prod_r.xvx) + ext(prod_r.yvy) + ext(prod_r.zvz);
    term_nxt.den  = den_s[48:0];
    term_nxt.zero = (den_s == '0);
    term_nxt.a    = ext(prod_r.ww) - ext(prod_r.xx) - ext(prod_r.yy) - ext(prod_r.zz);
    term_nxt.d2   = dot_s <<< 1;
    term_nxt.cx   = (ext(prod_r.yvz) - ext(prod_r.zvy)) <<< 1;
    term_nxt.cy   = (ext(prod_r.zvx) - ext(prod_r.xvz)) <<< 1;
    term_nxt.cz   = (ext(prod_r.xvy) - ext(prod_r.yvx)) <<< 1;
    term_nxt.beat = beat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      term_v_r <= 1'b0;
    end else if (adv) begin
      v1_r     <= in_v;
      term_v_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      beat_r <= in_d;
      term_r <= term_nxt;
    end
  end

  assign term_v = term_v_r;
  assign term_d = term_r;

endmodule

// ===== sv/qvr_numer.sv =====
// Rotation numerator: split wide products, sum per axis, form the rounding dividend.
module qvr_numer import qvr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  logic    term_v,
  input  terms_t  term_d,
  output logic    div_v,
  output div_in_t div_d
);

  logic signed [49:0] opa [3][3];
  logic signed [23:0] opb [3][3];
  logic signed [48:0] ph_nxt [3][3];
  logic signed [49:0] pl_nxt [3][3];
  logic signed [48:0] ph_r [3][3];
  logic signed [49:0] pl_r [3][3];
  logic [74:0] prod_nxt [3][3];
  logic [74:0] prod_r [3][3];
  logic [76:0] num_nxt [3];
  logic [76:0] num_r [3];
  logic [76:0] mag [3];
  carry_t  c_nxt, c3_r, c4_r, c5_r;
  div_in_t div_nxt, div_r;
  logic [3:0] v_r;

  always_comb begin
    opa[0][0] = term_d.a;  opb[0][0] = term_d.beat.vec_x;
    opa[1][0] = term_d.a;  opb[1][0] = term_d.beat.vec_y;
    opa[2][0] = term_d.a;  opb[2][0] = term_d.beat.vec_z;
    opa[0][1] = term_d.d2; opb[0][1] = term_d.beat.quat_x;
    opa[1][1] = term_d.d2; opb[1][1] = term_d.beat.quat_y;
    opa[2][1] = term_d.d2; opb[2][1] = term_d.beat.quat_z;
    opa[0][2] = term_d.cx; opb[0][2] = term_d.beat.quat_w;
    opa[1][2] = term_d.cy; opb[1][2] = term_d.beat.quat_w;
    opa[2][2] = term_d.cz; opb[2][2] = term_d.beat.quat_w;
    for (int j = 0; j < 3; j++) begin
      for (int t = 0; t < 3; t++) begin
        ph_nxt[j][t] = $signed(opa[j][t][49:25]) * opb[j][t];
        pl_nxt[j][t] = $signed({1'b0, opa[j][t][24:0]}) * opb[j][t];
      end
    end
    c_nxt.den  = term_d.den;
    c_nxt.vx   = term_d.beat.vec_x;
    c_nxt.vy   = term_d.beat.vec_y;
    c_nxt.vz   = term_d.beat.vec_z;
    c_nxt.zero = term_d.zero;
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int t = 0; t < 3; t++) begin
        prod_nxt[j][t] = {ph_r[j][t][48], ph_r[j][t], 25'd0} +
                         {{25{pl_r[j][t][49]}}, pl_r[j][t]};
      end
      num_nxt[j] = {{2{prod_r[j][0][74]}}, prod_r[j][0]} +
                   {{2{prod_r[j][1][74]}}, prod_r[j][1]} +
                   {{2{prod_r[j][2][74]}}, prod_r[j][2]};
    end
    for (int j = 0; j < 3; j++) begin
      div_nxt.neg[j] = num_r[j][76];
      mag[j]         = num_r[j][76] ? (77'd0 - num_r[j]) : num_r[j];
      div_nxt.m[j]   = {mag[j], 1'b0} + {29'd0, c5_r.den};
    end
    div_nxt.c = c5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[2:0], term_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        for (int t = 0; t < 3; t++) begin
          ph_r[j][t]   <= ph_nxt[j][t];
          pl_r[j][t]   <= pl_nxt[j][t];
          prod_r[j][t] <= prod_nxt[j][t];
        end
        num_r[j] <= num_nxt[j];
      end
      c3_r  <= c_nxt;
      c4_r  <= c3_r;
      c5_r  <= c4_r;
      div_r <= div_nxt;
    end
  end

  assign div_v = v_r[3];
  assign div_d = div_r;

endmodule

// ===== sv/qvr_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, then rounding clamp.
module qvr_divider import qvr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      div_v,
  input  div_in_t   div_d,
  output logic      fin_v,
  output out_beat_t fin_d
);

  typedef struct packed {
    logic [2:0][49:0]          rem;
    logic [2:0][DIV_BITS-1:0]  lo;
    logic [2:0][DIV_BITS-1:0]  q;
    logic [2:0]                neg;
    carry_t                    c;
  } div_st_t;

  function automatic div_st_t step(input div_st_t s);
    div_st_t     r;
    logic [49:0] d;
    logic [50:0] t;
    logic [50:0] diff;
    logic        ge;
    r = s;
    d = {s.c.den, 1'b0};
    for (int j = 0; j < 3; j++) begin
      t        = {s.rem[j], s.lo[j][DIV_BITS-1]};
      diff     = t - {1'b0, d};
      ge       = (t >= {1'b0, d});
      r.rem[j] = ge ? diff[49:0] : t[49:0];
      r.lo[j]  = s.lo[j] << 1;
      r.q[j]   = {s.q[j][DIV_BITS-2:0], ge};
    end
    return r;
  endfunction

  function automatic logic [23:0] clamp(input logic [DIV_BITS-1:0] q, input logic neg);
    logic [DIV_BITS-1:0] nq;
    nq = '0 - q;
    if (neg) begin
      return (q > Q_NEG_LIM) ? SAT_NEG : nq[23:0];
    end
    return (q > Q_POS_LIM) ? SAT_POS : q[23:0];
  endfunction

  div_st_t init;
  div_st_t cur [DIV_BITS];
  logic    cur_v [DIV_BITS];
  div_st_t st_r [DIV_BITS];
  logic    vld_r [DIV_BITS];
  out_beat_t fin_nxt, fin_r;
  logic      fin_v_r;
  div_st_t   last;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      init.rem[j] = div_d.m[j][DIV_BITS+49:DIV_BITS];
      init.lo[j]  = div_d.m[j][DIV_BITS-1:0];
      init.q[j]   = '0;
    end
    init.neg = div_d.neg;
    init.c   = div_d.c;
  end

  for (genvar s = 0; s < DIV_BITS; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign cur[s]   = init;
      assign cur_v[s] = div_v;
    end else begin : g_next
      assign cur[s]   = st_r[s-1];
      assign cur_v[s] = vld_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= cur_v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[s] <= step(cur[s]);
      end
    end
  end

  assign last = st_r[DIV_BITS-1];

  always_comb begin
    if (last.c.zero) begin
      fin_nxt.rot_x = last.c.vx;
      fin_nxt.rot_y = last.c.vy;
      fin_nxt.rot_z = last.c.vz;
    end else begin
      fin_nxt.rot_x = clamp(last.q[0], last.neg[0]);
      fin_nxt.rot_y = clamp(last.q[1], last.neg[1]);
      fin_nxt.rot_z = clamp(last.q[2], last.neg[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (adv) begin
      fin_v_r <= vld_r[DIV_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_r <= fin_nxt;
    end
  end

  assign fin_v = fin_v_r;
  assign fin_d = fin_r;

endmodule

// ===== sv/quaternion_vector_rotate_core.sv =====
// Top level of the quaternion vector rotation core with output register and skid.
//
// Input beat: raw quaternion (w, x, y, z) and vector (x, y, z), signed Q8.16,
// taken when in_valid and in_ready are both high. The quaternion need not be
// unit length; an all-zero quaternion passes the vector through unchanged.
// Output beat: the rotated vector, rounded to nearest with ties away from
// zero and saturated to Q8.16, offered on out_valid until out_ready.
// Path: an accepted beat passes two product stages, four numerator stages,
// 25 divider stages (one quotient bit each), the clamp stage and the output
// register, the first loaded at the accepting edge.
// Throughput: one beat per cycle, sustained while the receiver keeps up.
// Stall: a beat that reaches the output while out_valid waits goes into a
// one-entry skid; while the skid holds a beat the whole pipeline and
// in_ready hold, and nothing is lost or repeated.
// Reset: synchronous active-low rst_n clears all valid bits; no other state.
`include "quaternion_vector_rotate_core_defines.svh"
module quaternion_vector_rotate_core import qvr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  logic      adv;
  logic      term_v, div_v, fin_v;
  terms_t    term_d;
  div_in_t   div_d;
  out_beat_t fin_d;
  logic      out_v_r, sk_v_r;
  out_beat_t out_d_r, sk_d_r;

  assign adv      = !sk_v_r;
  assign in_ready = adv;

  qvr_terms u_terms (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_v   (in_valid),
    .in_d   (in_beat),
    .term_v (term_v),
    .term_d (term_d)
  );

  qvr_numer u_numer (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .term_v (term_v),
    .term_d (term_d),
    .div_v  (div_v),
    .div_d  (div_d)
  );

  qvr_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .div_v (div_v),
    .div_d (div_d),
    .fin_v (fin_v),
    .fin_d (fin_d)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (sk_v_r) begin
      if (out_ready) begin
        sk_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_ready) begin
      out_v_r <= fin_v;
    end else if (fin_v) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v_r) begin
      if (out_ready) begin
        out_d_r <= sk_d_r;
      end
    end else if (!out_v_r || out_ready) begin
      out_d_r <= fin_d;
    end else begin
      sk_d_r <= fin_d;
    end
  end

  assign out_valid = out_v_r;
  assign out_beat  = out_d_r;

  `QVR_ASSERT(a_skid_needs_out, sk_v_r |-> out_v_r, "skid holds a beat with no output beat")
  `QVR_ASSERT(a_skid_fill, out_v_r && !out_ready && fin_v && adv |=> sk_v_r, "stalled beat dropped")
  `QVR_ASSERT(a_skid_hold, sk_v_r && !out_ready |=> sk_v_r && $stable(sk_d_r), "skid beat lost")
  `QVR_ASSERT(a_skid_drain, sk_v_r && out_ready |=> out_d_r == $past(sk_d_r), "skid beat not moved out")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the quaternion vector rotation core.
module testbench;
  import qvr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [23:0] MAXV = 24'sh7FFFFF;
  localparam logic signed [23:0] MINV = 24'sh800000;
  localparam logic signed [23:0] ONE  = 24'sh010000;
  localparam int RANDOM_ITEMS = 830;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    in_beat_t  stim;
    bit        typed;
    out_beat_t rot;
  } row_t;

  typedef struct {
    bit        typed;
    out_beat_t rot;
  } pending_t;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_ready;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_beat_t out_beat;

  out_beat_t rot_queue[$];
  pending_t  offered[$];
  row_t      rows[$];
  int        accepted = 0;
  int        errors = 0;

  quaternion_vector_rotate_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_beat(in_beat),
    .out_valid(out_valid), .out_ready(out_ready), .out_beat(out_beat)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic logic signed [23:0] round_sat(logic signed [95:0] num,
                                                   logic signed [95:0] den);
    logic [95:0] mag;
    logic [95:0] q;
    logic        neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (2 * mag + den) / (2 * den);
    if (neg) begin
      if (q > 96'd8388608) return SAT_NEG;
      return -q[23:0];
    end
    if (q > 96'd8388607) return SAT_POS;
    return q[23:0];
  endfunction

  function automatic out_beat_t rotate_vector(in_beat_t b);
    logic signed [95:0] w, x, y, z, vx, vy, vz;
    logic signed [95:0] ww, uu, den, a, d2, cx, cy, cz;
    out_beat_t r;
    w = b.quat_w; x = b.quat_x; y = b.quat_y; z = b.quat_z;
    vx = b.vec_x; vy = b.vec_y; vz = b.vec_z;
    ww = w * w;
    uu = x * x + y * y + z * z;
    den = ww + uu;
    if (den == 0) begin
      r.rot_x = b.vec_x; r.rot_y = b.vec_y; r.rot_z = b.vec_z;
      return r;
    end
    a  = ww - uu;
    d2 = 2 * (x * vx + y * vy + z * vz);
    cx = 2 * (y * vz - z * vy);
    cy = 2 * (z * vx - x * vz);
    cz = 2 * (x * vy - y * vx);
    r.rot_x = round_sat(a * vx + d2 * x + cx * w, den);
    r.rot_y = round_sat(a * vy + d2 * y + cy * w, den);
    r.rot_z = round_sat(a * vz + d2 * z + cz * w, den);
    return r;
  endfunction

  function automatic logic signed [23:0] rand_comp(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($signed(24'($urandom_range(255))) - 128);
      2: return $urandom_range(1) ? MAXV : MINV;
      3: return '0;
      default: return $signed(24'($urandom_range(131071))) - ONE;
    endcase
  endfunction

  function automatic in_beat_t rand_beat();
    in_beat_t b;
    int qm;
    int vm;
    qm = $urandom_range(9);
    vm = $urandom_range(9);
    qm = qm < 4 ? 0 : qm < 7 ? 4 : qm < 8 ? 1 : qm < 9 ? 2 : 3;
    vm = vm < 5 ? 0 : vm < 8 ? 4 : vm < 9 ? 2 : 1;
    b.quat_w = rand_comp(qm); b.quat_x = rand_comp(qm);
    b.quat_y = rand_comp(qm); b.quat_z = rand_comp(qm);
    b.vec_x = rand_comp(vm); b.vec_y = rand_comp(vm); b.vec_z = rand_comp(vm);
    return b;
  endfunction

  function automatic row_t mk(logic signed [23:0] w, x, y, z, vx, vy, vz,
                              bit typed, logic signed [23:0] rx, ry, rz);
    row_t r;
    r.stim = '{w, x, y, z, vx, vy, vz};
    r.typed = typed;
    r.rot = '{rx, ry, rz};
    return r;
  endfunction

  function automatic bit quiet_phase();
    return accepted >= 500 && accepted < 650;
  endfunction

  task automatic offer(in_beat_t b, bit typed, out_beat_t rot);
    pending_t p;
    while (!quiet_phase() && $urandom_range(99) < 26) begin
      in_valid <= 0;
      @(posedge clk);
    end
    p.typed = typed;
    p.rot = rot;
    offered = {offered, p};
    in_valid <= 1;
    in_beat <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    rows = {rows, mk(0, 0, 0, 0, MAXV, MINV, 0, 1, MAXV, MINV, 0)};
    rows = {rows, mk(0, 0, 0, 0, MINV, MAXV, 123, 1, MINV, MAXV, 123)};
    rows = {rows, mk(ONE, 0, 0, 0, MAXV, MINV, 5, 1, MAXV, MINV, 5)};
    rows = {rows, mk(MAXV, 0, 0, 0, MINV, 7, MAXV, 1, MINV, 7, MAXV)};
    rows = {rows, mk(MINV, 0, 0, 0, 1, -1, MINV, 1, 1, -1, MINV)};
    rows = {rows, mk(0, ONE, 0, 0, ONE, ONE, ONE, 1, ONE, -ONE, -ONE)};
    rows = {rows, mk(0, 0, ONE, 0, ONE, ONE, ONE, 1, -ONE, ONE, -ONE)};
    rows = {rows, mk(0, 0, 0, ONE, ONE, ONE, ONE, 1, -ONE, -ONE, ONE)};
    rows = {rows, mk(0, 0, 0, 1, 3, 4, 5, 1, -3, -4, 5)};
    rows = {rows, mk(ONE, ONE, ONE, ONE, MAXV, MAXV, MAXV, 0, 0, 0, 0)};
    rows = {rows, mk(ONE, ONE, 0, 0, MAXV, MAXV, MAXV, 0, 0, 0, 0)};
    rows = {rows, mk(MAXV, MAXV, MAXV, MAXV, MINV, MINV, MINV, 0, 0, 0, 0)};
    rows = {rows, mk(MINV, MINV, MINV, MINV, MAXV, MINV, MAXV, 0, 0, 0, 0)};
    rows = {rows, mk(1, 1, 1, 1, MAXV, MAXV, MINV, 0, 0, 0, 0)};
    rows = {rows, mk(3, -2, 1, 0, 100, -200, 300, 0, 0, 0, 0)};
    rows = {rows, mk(MAXV, MINV, 1, -1, MAXV, MAXV, MAXV, 0, 0, 0, 0)};
    rows = {rows, mk(0, MAXV, MAXV, 0, MAXV, MINV, 0, 0, 0, 0, 0)};
    rows = {rows, mk(-ONE, 0, 0, 0, -1, 0, 1, 1, -1, 0, 1)};

    repeat (9) @(posedge clk);
    rst_n <= 1;
    foreach (rows[i]) offer(rows[i].stim, rows[i].typed, rows[i].rot);
    for (int i = 0; i < RANDOM_ITEMS; i++) offer(rand_beat(), 0, '0);
    in_valid <= 0;
    @(posedge clk);
    while (rot_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    int hold;
    bit held;
    held = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!held && accepted >= 300) begin
        held = 1;
        hold = 200;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else begin
        out_ready <= quiet_phase() || $urandom_range(99) >= 26;
      end
    end
  end

  always @(posedge clk) begin
    pending_t p;
    if (rst_n && in_valid && in_ready) begin
      p = offered.pop_front();
      rot_queue = {rot_queue, (p.typed ? p.rot : rotate_vector(in_beat))};
      accepted <= accepted + 1;
    end
  end

  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (rot_queue.size() == 0) begin
        $error("result beat with no expectation pending");
        errors++;
      end else begin
        e = rot_queue.pop_front();
        if (out_beat.rot_x !== e.rot_x) begin
          $error("rot_x expected %0d actual %0d", e.rot_x, out_beat.rot_x);
          errors++;
        end
        if (out_beat.rot_y !== e.rot_y) begin
          $error("rot_y expected %0d actual %0d", e.rot_y, out_beat.rot_y);
          errors++;
        end
        if (out_beat.rot_z !== e.rot_z) begin
          $error("rot_z expected %0d actual %0d", e.rot_z, out_beat.rot_z);
          errors++;
        end
      end
    end
  end

  initial begin
    #3ms;
    $display("Verification failed");
    $finish;
  end
endmodule
